// ===== rtl/ahs_pkg.sv =====
// ----------------------------------------------------------------------------
// ahs_pkg
// Shared types and codes for the axis homing sequencer: homing phases, motor
// modes, register indexes and the records passed between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package ahs_pkg;

  localparam int TimeW  = 32;
  localparam int SpeedW = 16;

  typedef enum logic [2:0] {
    PH_SEEK      = 3'd0,
    PH_BACK_OFF  = 3'd1,
    PH_RESEEK    = 3'd2,
    PH_SETTLE    = 3'd3,
    PH_MOVE_HOME = 3'd4,
    PH_COMPLETE  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    MODE_STOP = 3'd0,
    MODE_RUN  = 3'd1,
    MODE_ZERO = 3'd2,
    MODE_HOME = 3'd3,
    MODE_IDLE = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REG_SEEK_SPEED     = 3'd0,
    REG_BACK_OFF_SPEED = 3'd1,
    REG_RESEEK_SPEED   = 3'd2,
    REG_HOME_TARGET    = 3'd3,
    REG_DEBOUNCE_MS    = 3'd4,
    REG_SETTLE_MS      = 3'd5
  } reg_idx_t;

  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic signed [SpeedW-1:0] seek_speed;
    logic signed [SpeedW-1:0] back_off_speed;
    logic signed [SpeedW-1:0] reseek_speed;
    logic [15:0]              settle_ms;
  } back_cfg_t;

  typedef struct packed {
    logic             restart;
    logic             active;
    logic             rise;
    logic             fall;
    logic [TimeW-1:0] now_ms;
    logic             at_home;
  } step_t;

  typedef struct packed {
    mode_t                    motor_mode;
    logic signed [SpeedW-1:0] speed;
    phase_t                   phase;
    logic                     switch_active;
    logic                     switch_latched;
    logic                     homing_done;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/ahs_front.sv =====
// ----------------------------------------------------------------------------
// ahs_front
// Input side: debounces the low-active switch, finds active and release
// edges against the previous step and pushes one step record per item.
// ----------------------------------------------------------------------------
`default_nettype none

module ahs_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire logic                        command,
  input  wire logic                        raw_switch_level,
  input  wire logic [ahs_pkg::TimeW-1:0]   now_ms,
  input  wire logic                        at_home,
  input  wire logic [7:0]                  debounce_ms,
  input  wire logic                        sq_full,
  output      logic                        sq_push,
  output      ahs_pkg::step_t              sq_data
);
  import ahs_pkg::*;

  logic             last_raw_level;
  logic             stable_level;
  logic [TimeW-1:0] level_change_time;
  logic             prev_switch_active;

  logic             changed;
  logic [TimeW-1:0] change_time_eff;
  logic [TimeW-1:0] elapsed;
  logic             stable_next;
  logic             active_next;
  logic             is_restart;

  assign sq_push         = push && !sq_full;
  assign is_restart      = (command == CMD_RESTART);
  assign changed         = (raw_switch_level != last_raw_level);
  assign change_time_eff = changed ? now_ms : level_change_time;
  assign elapsed         = now_ms - change_time_eff;
  assign stable_next     = (elapsed > {{(TimeW-8){1'b0}}, debounce_ms})
                           ? raw_switch_level : stable_level;
  assign active_next     = !stable_next;

  always_comb begin
    sq_data.restart = is_restart;
    sq_data.now_ms  = now_ms;
    sq_data.at_home = at_home;
    if (is_restart) begin
      sq_data.active = !stable_level;
      sq_data.rise   = 1'b0;
      sq_data.fall   = 1'b0;
    end else begin
      sq_data.active = active_next;
      sq_data.rise   = active_next && !prev_switch_active;
      sq_data.fall   = !active_next && prev_switch_active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw_level     <= 1'b1;
      stable_level       <= 1'b1;
      level_change_time  <= '0;
      prev_switch_active <= 1'b0;
    end else if (sq_push && !is_restart) begin
      last_raw_level     <= raw_switch_level;
      stable_level       <= stable_next;
      level_change_time  <= change_time_eff;
      prev_switch_active <= active_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ahs_step_q.sv =====
// ----------------------------------------------------------------------------
// ahs_step_q
// Two-entry queue of classified step records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ahs_step_q (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ahs_pkg::step_t push_data,
  output      logic           full,
  input  wire logic           pop,
  output      logic           empty,
  output      ahs_pkg::step_t pop_data
);
  import ahs_pkg::*;

  step_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ahs_back.sv =====
// ----------------------------------------------------------------------------
// ahs_back
// Execution side: runs the homing phase machine, the settle timer, the
// switch latch and the done flag, one step record per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ahs_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ahs_pkg::back_cfg_t cfg,
  input  wire logic               sq_empty,
  input  wire ahs_pkg::step_t     sq_data,
  output      logic               sq_pop,
  input  wire logic               rq_full,
  output      logic               rq_push,
  output      ahs_pkg::result_t   rq_data
);
  import ahs_pkg::*;

  phase_t           phase;
  phase_t           phase_next;
  logic             settle_started;
  logic             settle_started_next;
  logic [TimeW-1:0] settle_start_time;
  logic [TimeW-1:0] settle_start_time_next;
  logic             latched_status;
  logic             latched_status_next;
  logic             done_flag;
  logic             done_flag_next;

  logic [TimeW-1:0] start_eff;
  logic             settle_over;

  assign sq_pop      = !sq_empty && !rq_full;
  assign rq_push     = sq_pop;
  assign start_eff   = settle_started ? settle_start_time : sq_data.now_ms;
  assign settle_over = ((sq_data.now_ms - start_eff) >= {16'd0, cfg.settle_ms});

  always_comb begin
    phase_next = phase;
    if (sq_data.restart) begin
      phase_next = PH_SEEK;
    end else begin
      case (phase)
        PH_SEEK:      if (sq_data.rise) phase_next = PH_BACK_OFF;
        PH_BACK_OFF:  if (sq_data.fall) phase_next = PH_RESEEK;
        PH_RESEEK:    if (sq_data.rise) phase_next = PH_SETTLE;
        PH_SETTLE:    if (settle_over) phase_next = PH_MOVE_HOME;
        PH_MOVE_HOME: if (sq_data.at_home) phase_next = PH_COMPLETE;
        default:      phase_next = phase;
      endcase
    end
  end

  always_comb begin
    rq_data.motor_mode     = MODE_STOP;
    rq_data.speed          = '0;
    settle_started_next    = settle_started;
    settle_start_time_next = settle_start_time;
    latched_status_next    = latched_status;
    done_flag_next         = done_flag;
    if (sq_data.restart) begin
      done_flag_next = 1'b0;
    end else begin
      case (phase)
        PH_SEEK: begin
          if (sq_data.rise) begin
            latched_status_next = 1'b1;
          end else begin
            rq_data.motor_mode = MODE_RUN;
            rq_data.speed      = cfg.seek_speed;
          end
        end
        PH_BACK_OFF: begin
          if (sq_data.fall) begin
            latched_status_next = 1'b0;
          end else begin
            rq_data.motor_mode = MODE_RUN;
            rq_data.speed      = cfg.back_off_speed;
          end
        end
        PH_RESEEK: begin
          if (sq_data.rise) begin
            latched_status_next = 1'b1;
          end else begin
            rq_data.motor_mode = MODE_RUN;
            rq_data.speed      = cfg.reseek_speed;
          end
        end
        PH_SETTLE: begin
          rq_data.motor_mode     = MODE_ZERO;
          settle_start_time_next = start_eff;
          settle_started_next    = !settle_over;
        end
        PH_MOVE_HOME: begin
          rq_data.motor_mode = sq_data.at_home ? MODE_IDLE : MODE_HOME;
          if (sq_data.fall) begin
            latched_status_next = 1'b0;
          end
        end
        default: begin
          rq_data.motor_mode = MODE_IDLE;
          done_flag_next     = 1'b1;
        end
      endcase
    end
    rq_data.phase          = phase_next;
    rq_data.switch_active  = sq_data.active;
    rq_data.switch_latched = latched_status_next;
    rq_data.homing_done    = done_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SEEK;
      settle_started    <= 1'b0;
      settle_start_time <= '0;
      latched_status    <= 1'b0;
      done_flag         <= 1'b0;
    end else if (sq_pop) begin
      phase             <= phase_next;
      settle_started    <= settle_started_next;
      settle_start_time <= settle_start_time_next;
      latched_status    <= latched_status_next;
      done_flag         <= done_flag_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ahs_result_q.sv =====
// ----------------------------------------------------------------------------
// ahs_result_q
// Two-entry output queue holding finished results until they are popped.
// ----------------------------------------------------------------------------
`default_nettype none

module ahs_result_q (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ahs_pkg::result_t push_data,
  output      logic             full,
  input  wire logic             pop,
  output      logic             empty,
  output      ahs_pkg::result_t pop_data
);
  import ahs_pkg::*;

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/axis_homing_sequencer.sv =====
// ----------------------------------------------------------------------------
// axis_homing_sequencer
// Homing controller for one stepper axis with a low-active limit switch.
//
//   channel  | handshake           | beat
//   ---------+---------------------+---------------------------------------
//   step in  | push / full         | command, raw_switch_level, now_ms,
//            |                     | at_home
//   result   | empty / pop         | motor_mode, speed, phase, switch_active,
//            |                     | switch_latched, homing_done
//   config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One step beat per clock sustained while results are popped; a result
// shows once its step has passed both queues (front writes the step queue
// at the accepting edge, back writes the result queue when it takes the step).
// Reset is synchronous; no clearing pass.
// A stalled result side fills the result queue, then the step queue, and
// only then raises full. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_homing_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output      logic        full,
  input  wire logic        command,
  input  wire logic        raw_switch_level,
  input  wire logic [31:0] now_ms,
  input  wire logic        at_home,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [2:0]  motor_mode,
  output      logic signed [15:0] speed,
  output      logic [2:0]  phase,
  output      logic        switch_active,
  output      logic        switch_latched,
  output      logic        homing_done,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import ahs_pkg::*;

  back_cfg_t bcfg;
  logic [7:0] debounce_ms;

  logic    sq_push;
  step_t   sq_in;
  logic    sq_full;
  logic    sq_pop;
  logic    sq_empty;
  step_t   sq_out;
  logic    rq_push;
  result_t rq_in;
  logic    rq_full;
  result_t rq_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bcfg.seek_speed     <= '0;
      bcfg.back_off_speed <= '0;
      bcfg.reseek_speed   <= '0;
      bcfg.settle_ms      <= 16'd100;
      debounce_ms         <= 8'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_SEEK_SPEED:     bcfg.seek_speed     <= cfg_data[15:0];
        REG_BACK_OFF_SPEED: bcfg.back_off_speed <= cfg_data[15:0];
        REG_RESEEK_SPEED:   bcfg.reseek_speed   <= cfg_data[15:0];
        REG_HOME_TARGET:    ;
        REG_DEBOUNCE_MS:    debounce_ms         <= cfg_data[7:0];
        REG_SETTLE_MS:      bcfg.settle_ms      <= cfg_data[15:0];
        default:            ;
      endcase
    end
  end

  ahs_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .command          (command),
    .raw_switch_level (raw_switch_level),
    .now_ms           (now_ms),
    .at_home          (at_home),
    .debounce_ms      (debounce_ms),
    .sq_full          (sq_full),
    .sq_push          (sq_push),
    .sq_data          (sq_in)
  );

  ahs_step_q u_step_q (
    .clk       (clk),
    .rst       (rst),
    .push      (sq_push),
    .push_data (sq_in),
    .full      (sq_full),
    .pop       (sq_pop),
    .empty     (sq_empty),
    .pop_data  (sq_out)
  );

  ahs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (bcfg),
    .sq_empty (sq_empty),
    .sq_data  (sq_out),
    .sq_pop   (sq_pop),
    .rq_full  (rq_full),
    .rq_push  (rq_push),
    .rq_data  (rq_in)
  );

  ahs_result_q u_result_q (
    .clk       (clk),
    .rst       (rst),
    .push      (rq_push),
    .push_data (rq_in),
    .full      (rq_full),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (rq_out)
  );

  assign full           = sq_full;
  assign motor_mode     = rq_out.motor_mode;
  assign speed          = rq_out.speed;
  assign phase          = rq_out.phase;
  assign switch_active  = rq_out.switch_active;
  assign switch_latched = rq_out.switch_latched;
  assign homing_done    = rq_out.homing_done;

endmodule

`default_nettype wire

// ===== rtl/ahs_checker.sv =====
// ----------------------------------------------------------------------------
// ahs_checker
// Port-level checks on the result channel of the homing sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ahs_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic [2:0]        motor_mode,
  input wire logic signed [15:0] speed,
  input wire logic [2:0]        phase,
  input wire logic              homing_done
);
  import ahs_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_done_only_complete: assert property (@(posedge clk) disable iff (rst)
    (!empty && homing_done) |-> (phase == PH_COMPLETE && motor_mode == MODE_IDLE))
    else $error("done reported outside complete phase");

  a_speed_only_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && speed != 16'sd0) |-> (motor_mode == MODE_RUN))
    else $error("nonzero speed outside run mode");

  a_zero_in_settle: assert property (@(posedge clk) disable iff (rst)
    (!empty && motor_mode == MODE_ZERO) |->
      (phase == PH_SETTLE || phase == PH_MOVE_HOME))
    else $error("zero command outside settle");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(speed) && $stable(phase)))
    else $error("waiting result changed");

endmodule

bind axis_homing_sequencer ahs_checker u_ahs_checker (.*);

`default_nettype wire
